// ===== src/ska_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ska_pkg
// Shared types and codes for the seed/key access judge and its checker.
// ----------------------------------------------------------------------------
package ska_pkg;

    localparam int unsigned MAX_LEVEL = 8;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [7:0]  ATTEMPTS_DEFAULT = 8'd3;
    localparam logic [31:0] DELAY_DEFAULT    = 32'd10000000;
    localparam logic [31:0] DELAY_HALF_RANGE = 32'h8000_0000;
    localparam logic [7:0]  COUNT_SAT        = 8'hFF;
    localparam logic [8:0]  HEADER_LEN       = 9'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_ENABLE  = 3'd0,
        REG_SEED_LENGTHS  = 3'd1,
        REG_KEY_LENGTHS   = 3'd2,
        REG_MAX_ATTEMPTS  = 3'd3,
        REG_LOCKOUT_DELAY = 3'd4
    } cfg_reg_t;

    // Response codes
    typedef enum logic [3:0] {
        RC_POSITIVE    = 4'd0,
        RC_TOO_LONG    = 4'd1,
        RC_CONDITIONS  = 4'd2,
        RC_SEQUENCE    = 4'd3,
        RC_LENGTH      = 4'd4,
        RC_INVALID_KEY = 4'd5,
        RC_EXCEEDED    = 4'd6,
        RC_DELAY       = 4'd7,
        RC_UNSUPPORTED = 4'd8,
        RC_PASSTHROUGH = 4'd9
    } resp_code_t;

    // Seed actions
    typedef enum logic [1:0] {
        SEED_NONE      = 2'd0,
        SEED_ZERO      = 2'd1,
        SEED_GENERATED = 2'd2
    } seed_action_t;

    // Request item as packed in s_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [1:0]  pad;
        logic        key_valid;
        logic [7:0]  generated_seed_length;
        logic        seed_generated_ok;
        logic [3:0]  current_level;
        logic [11:0] response_capacity;
        logic [11:0] request_length;
        logic [31:0] now_time;
        logic        suppress_response;
        logic [6:0]  sub_function;
    } in_item_t;

    // Result item as packed in m_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [4:0]   pad;
        logic [31:0]  lockout_remaining;
        logic         lockout_active;
        logic [7:0]   attempt_count;
        logic [3:0]   granted_level;
        seed_action_t seed_action;
        logic [6:0]   echo_sub;
        logic [8:0]   response_length;
        resp_code_t   response_code;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/seed_key_access_lockout.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seed_key_access_lockout
// Judges security-access seed requests and keys, tracks the pending seed,
// the failed-attempt count and a wrap-safe lockout deadline.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                          Content
//  request   in   s_tvalid/s_tready/s_tdata/s_tuser one request item per transfer
//  result    out  m_tvalid/m_tready/m_tdata        one result item per request
//  config    in   cfg_write/cfg_index/cfg_data     register write, no read-back
//
//  A request enters the input register, is judged combinationally against
//  the session state and lands in the result register; one request per
//  cycle is sustained while m_tready is high. The result register is the
//  only stall point; while it holds an untaken result the input register
//  still fills. Reset clears state and loads the register defaults (3
//  attempts, 10000000 time units of lockout).
// ----------------------------------------------------------------------------
module seed_key_access_lockout
    import ska_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_tdata, low bit up: sub_function, suppress_response, now_time,
    // request_length, response_capacity, current_level, seed_generated_ok,
    // generated_seed_length, key_valid, zero pad
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: is_request_phase
    input  wire logic                  s_tuser,
    // m_tdata, low bit up: response_code, response_length, echo_sub,
    // seed_action, granted_level, attempt_count, lockout_active,
    // lockout_remaining, zero pad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [7:0]  level_enable_reg;
    logic [63:0] seed_lengths_reg;
    logic [63:0] key_lengths_reg;
    logic [7:0]  max_attempts_reg;
    logic [31:0] lockout_delay_reg;

    // Session state
    logic [7:0]  fail_count_reg,    fail_count_next;
    logic        waiting_reg,       waiting_next;
    logic [31:0] deadline_reg,      deadline_next;
    logic [3:0]  pend_level_reg,    pend_level_next;
    logic [7:0]  pend_seed_len_reg, pend_seed_len_next;

    // Pipeline registers
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        in_phase_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg, out_item_next;

    logic        advance;

    // Judge signals
    logic [31:0] now_minus_deadline;
    logic        deadline_reached;
    logic        locked;
    logic [5:0]  sub_plus;
    logic [3:0]  level;
    logic [2:0]  level_idx;
    logic        level_ok;
    logic [7:0]  seed_bytes;
    logic [7:0]  key_len;
    logic [12:0] seed_need;
    logic [8:0]  key_need;
    logic [7:0]  attempt_limit;
    logic [31:0] delay_eff;
    logic [7:0]  fail_base;
    logic [7:0]  fail_inc;
    logic        lock_start;
    resp_code_t  code;
    logic [8:0]  rlen;
    seed_action_t action;
    logic [3:0]  granted;
    logic [31:0] remaining;

    // Handshake: move the input item forward when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_enable_reg  <= '0;
            seed_lengths_reg  <= '0;
            key_lengths_reg   <= '0;
            max_attempts_reg  <= ATTEMPTS_DEFAULT;
            lockout_delay_reg <= DELAY_DEFAULT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEVEL_ENABLE:  level_enable_reg  <= cfg_data[7:0];
                REG_SEED_LENGTHS:  seed_lengths_reg  <= cfg_data;
                REG_KEY_LENGTHS:   key_lengths_reg   <= cfg_data;
                REG_MAX_ATTEMPTS:  max_attempts_reg  <= cfg_data[7:0];
                REG_LOCKOUT_DELAY: lockout_delay_reg <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // Capture a request transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg  <= in_item_t'(s_tdata);
            in_phase_reg <= s_tuser;
        end
    end

    // Lockout deadline compare, safe across wrap
    assign now_minus_deadline = in_item_reg.now_time - deadline_reg;
    assign deadline_reached   = !now_minus_deadline[31];
    assign locked             = waiting_reg && !deadline_reached;

    // Decode level from sub-function: 2L-1 and 2L both name level L
    assign sub_plus  = {1'b0, in_item_reg.sub_function[4:0]} + 6'd1;
    assign level     = sub_plus[4:1];
    assign level_idx = 3'(level - 4'd1);
    assign level_ok  = (in_item_reg.sub_function != 7'd0)
                    && ({25'd0, in_item_reg.sub_function} <= 32'(2 * MAX_LEVEL))
                    && level_enable_reg[level_idx];

    assign seed_bytes = seed_lengths_reg[{level_idx, 3'b000} +: 8];
    assign key_len    = key_lengths_reg[{level_idx, 3'b000} +: 8];
    assign seed_need  = 13'(seed_bytes) + 13'(HEADER_LEN);
    assign key_need   = 9'(key_len) + HEADER_LEN;

    // Zero limits fall back to the defaults
    assign attempt_limit = (max_attempts_reg == 8'd0) ? ATTEMPTS_DEFAULT : max_attempts_reg;
    assign delay_eff     = (lockout_delay_reg == 32'd0) ? DELAY_DEFAULT : lockout_delay_reg;

    // An expired wait clears the count before the request is judged
    assign fail_base = waiting_reg ? 8'd0 : fail_count_reg;
    assign fail_inc  = (fail_base == COUNT_SAT) ? fail_base : fail_base + 8'd1;

    // Judge the request and derive the next session state
    always_comb
    begin
        code               = RC_PASSTHROUGH;
        rlen               = 9'd0;
        action             = SEED_NONE;
        granted            = 4'd0;
        lock_start         = 1'b0;
        fail_count_next    = fail_count_reg;
        waiting_next       = waiting_reg;
        deadline_next      = deadline_reg;
        pend_level_next    = pend_level_reg;
        pend_seed_len_next = pend_seed_len_reg;
        if (in_phase_reg)
        begin
            code = RC_POSITIVE;
            if (locked)
            begin
                code = RC_DELAY;
            end
            else
            begin
                if (waiting_reg)
                begin
                    waiting_next    = 1'b0;
                    fail_count_next = 8'd0;
                end
                priority if (!level_ok)
                begin
                    code = RC_UNSUPPORTED;
                end
                else if (in_item_reg.sub_function[0])
                begin
                    // Seed request
                    priority if ({1'b0, in_item_reg.response_capacity} < seed_need)
                    begin
                        code = RC_TOO_LONG;
                    end
                    else if (in_item_reg.suppress_response)
                    begin
                        pend_level_next    = 4'd0;
                        pend_seed_len_next = 8'd0;
                        rlen               = HEADER_LEN;
                    end
                    else if (in_item_reg.current_level == level)
                    begin
                        pend_level_next    = 4'd0;
                        pend_seed_len_next = 8'd0;
                        rlen               = seed_need[8:0];
                        action             = SEED_ZERO;
                    end
                    else if (!in_item_reg.seed_generated_ok)
                    begin
                        code = RC_CONDITIONS;
                    end
                    else if (in_item_reg.generated_seed_length != seed_bytes)
                    begin
                        pend_level_next    = 4'd0;
                        pend_seed_len_next = 8'd0;
                        code               = RC_CONDITIONS;
                    end
                    else
                    begin
                        pend_level_next    = level;
                        pend_seed_len_next = seed_bytes;
                        rlen               = seed_need[8:0];
                        action             = SEED_GENERATED;
                    end
                end
                else
                begin
                    // Key
                    priority if (pend_level_reg != level)
                    begin
                        code = RC_SEQUENCE;
                    end
                    else if (in_item_reg.request_length != 12'(key_need))
                    begin
                        code = RC_LENGTH;
                    end
                    else if (in_item_reg.response_capacity < 12'(HEADER_LEN))
                    begin
                        code = RC_TOO_LONG;
                    end
                    else if (!in_item_reg.key_valid)
                    begin
                        pend_level_next    = 4'd0;
                        pend_seed_len_next = 8'd0;
                        fail_count_next    = fail_inc;
                        if (fail_inc >= attempt_limit)
                        begin
                            waiting_next  = 1'b1;
                            deadline_next = in_item_reg.now_time + delay_eff;
                            lock_start    = 1'b1;
                            code          = RC_EXCEEDED;
                        end
                        else
                        begin
                            code = RC_INVALID_KEY;
                        end
                    end
                    else
                    begin
                        pend_level_next    = 4'd0;
                        pend_seed_len_next = 8'd0;
                        fail_count_next    = 8'd0;
                        granted            = level;
                        rlen               = HEADER_LEN;
                    end
                end
            end
        end
    end

    // Time left in lockout; a fresh wait still runs while delay fits half the range
    always_comb
    begin
        if (lock_start)
        begin
            remaining = (delay_eff <= DELAY_HALF_RANGE) ? delay_eff : 32'd0;
        end
        else if (locked)
        begin
            remaining = deadline_reg - in_item_reg.now_time;
        end
        else
        begin
            remaining = 32'd0;
        end
    end

    // Assemble the result item
    always_comb
    begin
        out_item_next                   = '0;
        out_item_next.response_code     = code;
        out_item_next.response_length   = rlen;
        out_item_next.echo_sub          = in_item_reg.sub_function;
        out_item_next.seed_action       = action;
        out_item_next.granted_level     = granted;
        out_item_next.attempt_count     = fail_count_next;
        out_item_next.lockout_active    = waiting_next;
        out_item_next.lockout_remaining = remaining;
    end

    // Advance session state with each judged request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count_reg    <= '0;
            waiting_reg       <= 1'b0;
            deadline_reg      <= '0;
            pend_level_reg    <= '0;
            pend_seed_len_reg <= '0;
        end
        else if (advance)
        begin
            fail_count_reg    <= fail_count_next;
            waiting_reg       <= waiting_next;
            deadline_reg      <= deadline_next;
            pend_level_reg    <= pend_level_next;
            pend_seed_len_reg <= pend_seed_len_next;
        end
    end

    // Hold the result until the transfer on the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ska_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ska_checker
// Port-level checks on the result stream of the seed/key access judge.
// ----------------------------------------------------------------------------
module ska_checker
    import ska_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    out_item_t res;

    assign res = out_item_t'(m_tdata);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No time left unless a lockout is in force
    a_remaining_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.lockout_active |-> res.lockout_remaining == 32'd0)
        else $error("lockout time left without a lockout");

    // A grant is a positive two-byte answer with no seed
    a_grant_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.granted_level != 4'd0 |->
            res.response_code == RC_POSITIVE && res.response_length == HEADER_LEN
            && res.seed_action == SEED_NONE)
        else $error("grant without a positive answer");

    // Only positive answers carry a length or a seed
    a_negative_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.response_code != RC_POSITIVE |->
            res.response_length == 9'd0 && res.seed_action == SEED_NONE)
        else $error("negative answer with payload");

    // Starting a lockout reports the wait as active
    a_exceeded_locks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.response_code == RC_EXCEEDED |-> res.lockout_active)
        else $error("attempt limit without lockout");

endmodule

bind seed_key_access_lockout ska_checker u_ska_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
